### hdl/ssseq_pkg.sv
// Shared types and constants for the converter soft-start sequencer.
package ssseq_pkg;

	localparam int unsigned CmdW    = 3;
	localparam int unsigned RefW    = 12;
	localparam int unsigned RampW   = 13;
	localparam int unsigned DelayW  = 16;
	localparam int unsigned CfgIdxW = 2;

	localparam logic [RampW-1:0]  RAMP_STEP        = RampW'(4);
	localparam logic [DelayW-1:0] ON_DELAY_RESET   = DelayW'(5000);
	localparam logic [DelayW-1:0] GOOD_DELAY_RESET = DelayW'(2000);

	typedef enum logic [2:0] {
		PH_INIT       = 3'd0,
		PH_LAUNCH     = 3'd1,
		PH_STANDBY    = 3'd2,
		PH_ON_DELAY   = 3'd3,
		PH_RAMP       = 3'd4,
		PH_GOOD_DELAY = 3'd5,
		PH_COMPLETE   = 3'd6,
		PH_FAULT      = 3'd7
	} phase_t;

	typedef enum logic [2:0] {
		ST_OFF     = 3'd0,
		ST_STANDBY = 3'd1,
		ST_START   = 3'd2,
		ST_ON      = 3'd3,
		ST_FAULT   = 3'd4
	} status_t;

	typedef enum logic [CmdW-1:0] {
		CMD_TICK        = 3'd0,
		CMD_ADC_SAMPLE  = 3'd1,
		CMD_SET_GO      = 3'd2,
		CMD_ENABLE      = 3'd3,
		CMD_DISABLE     = 3'd4,
		CMD_CLEAR_FAULT = 3'd5,
		CMD_FORCE_FAULT = 3'd6
	} cmd_t;

	typedef enum logic [CfgIdxW-1:0] {
		CFG_ON_DELAY   = 2'd0,
		CFG_GOOD_DELAY = 2'd1,
		CFG_SELF_START = 2'd2
	} cfg_idx_t;

	typedef struct packed {
		logic [CmdW-1:0] command;
		logic [RefW-1:0] target_reference;
	} in_item_t;

	typedef struct packed {
		logic [2:0]       phase;
		logic [2:0]       run_status;
		logic             pwm_output_on;
		logic             loop_on;
		logic             ramp_reference_used;
		logic [RampW-1:0] ramp_value;
		logic             fault_flag;
		logic             adc_seen_flag;
	} out_item_t;

	typedef struct packed {
		logic [DelayW-1:0] on_delay;
		logic [DelayW-1:0] good_delay;
		logic              self_start;
	} cfg_t;

	typedef struct packed {
		phase_t            phase;
		status_t           status;
		logic [DelayW-1:0] count;
		logic [RampW-1:0]  ramp;
		logic              enabled;
		logic              go;
		logic              fault;
		logic              adc_seen;
		logic              pwm_on;
		logic              loop_on;
		logic              ramp_used;
	} seq_state_t;

endpackage

### hdl/converter_soft_start_sequencer.sv
// Top level of the converter soft-start sequencer.
//
// Each command item (tick, ADC sample, set go, enable, disable, clear fault or
// force fault) updates the sequencer state and yields
// exactly one result item reporting the state after the update: phase, status,
// PWM and loop enables, reference source and ramp value, fault and ADC-seen
// flags. The next state is formed by a short block of logic between the state
// registers and a one-entry result register, so a new item is taken every cycle
// while the command side is not stalled; its result appears on the cycle after
// acceptance. The command side is stalled only while the result register holds
// an item that the consumer is stalling; unused command code 7 changes nothing
// but still returns a result. Configuration (power-on delay, power-good delay,
// self-start) is written through a separate valid/ready port that is always
// ready, and should only be written while no item is in flight.
module converter_soft_start_sequencer import ssseq_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  in_item_t           cmd,
	output logic               res_valid,
	input  logic               res_stall,
	output out_item_t          res,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [DelayW-1:0]  cfg_data
);

	cfg_t       cfg;
	seq_state_t state_q;
	seq_state_t state_nxt;
	out_item_t  res_q;
	logic       res_valid_q;
	logic       accept;

	// Configuration writes are always taken.
	assign cfg_ready = 1'b1;

	ssseq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ssseq_next u_next (
		.cur  (state_q),
		.item (cmd),
		.cfg  (cfg),
		.nxt  (state_nxt)
	);

	// The result register can take a new item unless it is full and stalled.
	assign cmd_stall = res_valid_q & res_stall;
	assign accept    = cmd_valid & ~cmd_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{phase: PH_INIT, status: ST_OFF, default: '0};
		end else if (accept) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// The result payload reports the state after this item's update.
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q.phase               <= state_nxt.phase;
			res_q.run_status          <= state_nxt.status;
			res_q.pwm_output_on       <= state_nxt.pwm_on;
			res_q.loop_on             <= state_nxt.loop_on;
			res_q.ramp_reference_used <= state_nxt.ramp_used;
			res_q.ramp_value          <= state_nxt.ramp;
			res_q.fault_flag          <= state_nxt.fault;
			res_q.adc_seen_flag       <= state_nxt.adc_seen;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

### hdl/ssseq_cfg.sv
// Configuration register file of the soft-start sequencer.
module ssseq_cfg import ssseq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [CfgIdxW-1:0]  wr_index,
	input  logic [DelayW-1:0]   wr_data,
	output cfg_t                cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.on_delay   <= ON_DELAY_RESET;
			cfg_q.good_delay <= GOOD_DELAY_RESET;
			cfg_q.self_start <= 1'b0;
		end else if (wr_en) begin
			unique case (wr_index)
				CFG_ON_DELAY:   cfg_q.on_delay   <= wr_data;
				CFG_GOOD_DELAY: cfg_q.good_delay <= wr_data;
				CFG_SELF_START: cfg_q.self_start <= wr_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

### hdl/ssseq_next.sv
// Next-state logic of the soft-start sequencer for one command.
module ssseq_next import ssseq_pkg::*; (
	input  seq_state_t cur,
	input  in_item_t   item,
	input  cfg_t       cfg,
	output seq_state_t nxt
);

	logic [RampW-1:0] ramp_inc;

	assign ramp_inc = cur.ramp + RAMP_STEP;

	always_comb begin
		nxt = cur;
		unique case (item.command)
			CMD_TICK: begin
				unique case (cur.phase)
					PH_INIT: begin
						nxt.count     = '0;
						nxt.ramp      = '0;
						nxt.loop_on   = 1'b0;
						nxt.ramp_used = 1'b0;
						nxt.status    = ST_OFF;
						nxt.phase     = PH_LAUNCH;
					end
					PH_LAUNCH: begin
						nxt.status = ST_OFF;
						nxt.phase  = PH_STANDBY;
					end
					PH_STANDBY: begin
						nxt.status  = ST_STANDBY;
						nxt.pwm_on  = 1'b0;
						nxt.loop_on = 1'b0;
						if (cur.enabled && cur.adc_seen && !cur.fault && cur.go) begin
							nxt.count = '0;
							nxt.phase = PH_ON_DELAY;
						end
					end
					PH_ON_DELAY: begin
						nxt.status = ST_START;
						if (cur.count > cfg.on_delay) begin
							nxt.ramp      = '0;
							nxt.ramp_used = 1'b1;
							nxt.count     = '0;
							nxt.phase     = PH_RAMP;
						end else begin
							nxt.count = cur.count + 1'b1;
						end
					end
					PH_RAMP: begin
						nxt.status  = ST_START;
						nxt.pwm_on  = 1'b1;
						nxt.loop_on = 1'b1;
						nxt.ramp    = ramp_inc;
						if (ramp_inc >= {1'b0, item.target_reference}) begin
							nxt.count = '0;
							nxt.phase = PH_GOOD_DELAY;
						end
					end
					PH_GOOD_DELAY: begin
						nxt.status = ST_START;
						if (cur.count > cfg.good_delay) begin
							nxt.count = '0;
							nxt.phase = PH_COMPLETE;
						end else begin
							nxt.count = cur.count + 1'b1;
						end
					end
					PH_COMPLETE: begin
						nxt.status    = ST_ON;
						nxt.ramp_used = 1'b0;
					end
					PH_FAULT: begin
						nxt.status   = ST_FAULT;
						nxt.fault    = 1'b1;
						nxt.adc_seen = 1'b0;
						nxt.phase    = PH_STANDBY;
					end
				endcase
				// The go request lasts one tick unless self-start holds it.
				if (cfg.self_start) begin
					nxt.enabled = 1'b1;
					nxt.go      = 1'b1;
				end else begin
					nxt.go = 1'b0;
				end
			end
			CMD_ADC_SAMPLE:  nxt.adc_seen = 1'b1;
			CMD_SET_GO:      nxt.go       = 1'b1;
			CMD_ENABLE:      nxt.enabled  = 1'b1;
			CMD_DISABLE:     nxt.enabled  = 1'b0;
			CMD_CLEAR_FAULT: nxt.fault    = 1'b0;
			CMD_FORCE_FAULT: begin
				nxt.fault = 1'b1;
				nxt.phase = PH_FAULT;
			end
			default: ;
		endcase
	end

endmodule

### hdl/ssseq_chk.sv
// Port-level checks for the converter soft-start sequencer, bound to the top level.
module ssseq_chk import ssseq_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_stall,
	input logic               res_valid,
	input logic               res_stall,
	input out_item_t          res
);

	// A stalled result holds until it is taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result changed or vanished");

	// Every accepted item yields a result on the following cycle.
	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> res_valid)
		else $error("accepted item produced no result");

	// The command side is only held back by a waiting result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> !cmd_stall)
		else $error("command stalled with empty result register");

	// The ramp phase always runs from the ramp reference in the starting status.
	a_ramp_phase: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.phase == PH_RAMP |->
			res.run_status == ST_START && res.ramp_reference_used)
		else $error("ramp phase reported inconsistent status");

	// The start-up phases are only reached with an ADC sample seen.
	a_adc_seen: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res.phase == PH_ON_DELAY || res.phase == PH_RAMP ||
			res.phase == PH_GOOD_DELAY || res.phase == PH_COMPLETE) |->
			res.adc_seen_flag)
		else $error("start-up phase without ADC sample");

endmodule

bind converter_soft_start_sequencer ssseq_chk u_ssseq_chk (.*);
